/* hw/rtl/ssmm_pkg.sv */
// Shared types, field widths and operation/status codes for the sample stack.
package ssmm_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned IN_DATA_W  = ID_W + VAL_W;
  localparam int unsigned OUT_BITS   = STATUS_W + POS_W + COUNT_W + 2 * VAL_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ID_W-1:0]         id;
  } entry_t;

  typedef struct packed {
    logic id_eq;
    logic below_min;
    logic above_max;
  } cmp_flags_t;

endpackage

/* hw/rtl/ssmm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module ssmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ssmm_cmp.sv */
// Shared compare unit: ID equality and signed compares against the running min and max.
module ssmm_cmp (
  input  logic [ssmm_pkg::ID_W-1:0]         id_a_i,
  input  logic [ssmm_pkg::ID_W-1:0]         id_b_i,
  input  logic signed [ssmm_pkg::VAL_W-1:0] value_i,
  input  logic signed [ssmm_pkg::VAL_W-1:0] min_i,
  input  logic signed [ssmm_pkg::VAL_W-1:0] max_i,
  output ssmm_pkg::cmp_flags_t              flags_o
);
  import ssmm_pkg::*;

  always_comb begin
    flags_o.id_eq     = (id_a_i == id_b_i);
    flags_o.below_min = (value_i < min_i);
    flags_o.above_max = (value_i > max_i);
  end

endmodule

/* hw/rtl/sample_stack_min_max.sv */
// Top level of the sample stack: sequencer, state registers, entry RAM and output register.
//
// The block keeps a LIFO of up to DEPTH samples (16-bit ID, signed Q16.16 value).
// Items enter on the s_axis channel: tuser carries the operation (add, find,
// remove head), tdata carries the ID and the value. Every item yields exactly one
// result item on the m_axis channel with a status, the head-based position of a
// found ID, the entry count and the current minimum and maximum (zero when empty).
// Stored entries live in one RAM with a registered read port. A small sequencer
// walks that RAM one entry per cycle and feeds a single shared compare unit, which
// checks IDs for add and find, updates min/max on an add and rebuilds them after a remove.
// An item with no walk (unused kind, find or remove on an empty store, removal of
// the last entry) goes straight to the final step, and an add to an empty store
// goes straight to the write step. Otherwise a find or add walks the entries from
// the head until an ID hits or the walk ends, and an add that finds no duplicate
// then writes it or reports a full store; a remove walks every remaining entry.
// s_axis_tready_o is high only while the sequencer is idle, so one item is in work at
// a time. The result sits in an output register and the next item is accepted while
// it waits; if the receiver stalls, the sequencer holds in its final step until that
// register frees. After reset the store is empty, min and max read zero, and no
// clearing pass is needed.
module sample_stack_min_max #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [15:0] sample_id, [47:16] sample_value
  input  logic [ssmm_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [1:0] kind
  input  logic [ssmm_pkg::KIND_W-1:0]        s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [2:0] status, [6:3] position, [11:7] entry_count, [43:12] min_value,
  // [75:44] max_value, [79:76] zero
  output logic [ssmm_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import ssmm_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (AW > POS_W) ? AW : POS_W;
  localparam int unsigned NW = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CW-1:0]           occ_q, occ_d;
  logic signed [VAL_W-1:0] min_q, min_d, max_q, max_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    vld_q, vld_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic [KIND_W-1:0]       kind_q, kind_d;
  logic [ID_W-1:0]         id_q, id_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [STATUS_W-1:0]     res_status_q, res_status_d;
  logic [AW-1:0]           res_pos_q, res_pos_d;

  logic                    m_vld_q, m_vld_d;
  logic [OUT_BITS-1:0]     m_data_q, m_data_d;

  logic                    accept;
  logic                    out_free;
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [CW-1:0]           head_rel;
  entry_t                  ram_wdata, ram_rdata;
  logic signed [VAL_W-1:0] cmp_val;
  cmp_flags_t              flags;
  logic [PW-1:0]           pos_wide;
  logic [NW-1:0]           count_wide;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_vld_q || m_axis_tready_i;

  assign ram_wdata.id    = id_q;
  assign ram_wdata.value = val_q;
  assign head_rel        = occ_q - CW'(1) - cnt_q;
  assign cmp_val         = (state_q == S_PUSH) ? val_q : ram_rdata.value;

  ssmm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (occ_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ssmm_cmp u_cmp (
    .id_a_i  (ram_rdata.id),
    .id_b_i  (id_q),
    .value_i (cmp_val),
    .min_i   (min_q),
    .max_i   (max_q),
    .flags_o (flags)
  );

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    min_d        = min_q;
    max_d        = max_q;
    cnt_d        = cnt_q;
    vld_d        = 1'b0;
    pos_d        = pos_q;
    kind_d       = kind_q;
    id_d         = id_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = cnt_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d       = s_axis_tuser_i;
          id_d         = s_axis_tdata_i[ID_W-1:0];
          val_d        = s_axis_tdata_i[IN_DATA_W-1:ID_W];
          res_status_d = ST_OK;
          res_pos_d    = '0;
          cnt_d        = '0;
          case (s_axis_tuser_i)
            KIND_ADD: begin
              state_d = (occ_q == '0) ? S_PUSH : S_SCAN;
            end
            KIND_FIND: begin
              if (occ_q == '0) begin
                res_status_d = ST_NOTFOUND;
                state_d      = S_FIN;
              end else begin
                state_d = S_SCAN;
              end
            end
            KIND_REMOVE: begin
              if (occ_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_FIN;
              end else begin
                occ_d = occ_q - CW'(1);
                if (occ_q == CW'(1)) begin
                  min_d   = '0;
                  max_d   = '0;
                  state_d = S_FIN;
                end else begin
                  state_d = S_SCAN;
                end
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // A remove rebuilds min and max from the oldest entry upward.
        if (vld_q && (kind_q == KIND_REMOVE)) begin
          if (pos_q == '0) begin
            min_d = ram_rdata.value;
            max_d = ram_rdata.value;
          end else begin
            if (flags.below_min) min_d = ram_rdata.value;
            if (flags.above_max) max_d = ram_rdata.value;
          end
        end

        if (vld_q && (kind_q != KIND_REMOVE) && flags.id_eq) begin
          if (kind_q == KIND_FIND) begin
            res_pos_d = pos_q;
          end else begin
            res_status_d = ST_DUP;
          end
          state_d = S_FIN;
        end else if (vld_q && (CW'(pos_q) == occ_q - CW'(1))) begin
          case (kind_q)
            KIND_ADD:  state_d = S_PUSH;
            KIND_FIND: begin
              res_status_d = ST_NOTFOUND;
              state_d      = S_FIN;
            end
            default:   state_d = S_FIN;
          endcase
        end else if (cnt_q < occ_q) begin
          ram_re    = 1'b1;
          ram_raddr = (kind_q == KIND_REMOVE) ? cnt_q[AW-1:0] : head_rel[AW-1:0];
          cnt_d     = cnt_q + CW'(1);
          vld_d     = 1'b1;
          pos_d     = cnt_q[AW-1:0];
        end
      end

      S_PUSH: begin
        if (occ_q == CW'(DEPTH)) begin
          res_status_d = ST_FULL;
        end else begin
          ram_we = 1'b1;
          occ_d  = occ_q + CW'(1);
          if (occ_q == '0) begin
            min_d = val_q;
            max_d = val_q;
          end else begin
            if (flags.below_min) min_d = val_q;
            if (flags.above_max) max_d = val_q;
          end
        end
        state_d = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result assembly: the store state is already final when the sequencer reaches S_FIN.
  assign pos_wide   = PW'(res_pos_q);
  assign count_wide = NW'(occ_q);
  assign m_data_d   = {max_q, min_q, count_wide[COUNT_W-1:0], pos_wide[POS_W-1:0],
                       res_status_q};

  always_comb begin
    m_vld_d = m_vld_q;
    if ((state_q == S_FIN) && out_free) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      vld_q   <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      min_q   <= min_d;
      max_q   <= max_d;
      vld_q   <= vld_d;
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    pos_q        <= pos_d;
    kind_q       <= kind_d;
    id_q         <= id_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    if ((state_q == S_FIN) && out_free) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, m_data_q};

`ifndef SYNTHESIS
  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (occ_q < CW'(DEPTH)))
    else $error("entry write while store is full");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("second item accepted while one is in work");

  a_read_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (state_q == S_SCAN))
    else $error("entry read data arrived outside a walk");

  a_empty_extremes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) && (state_q == S_IDLE) |-> (min_q == '0) && (max_q == '0))
    else $error("min or max nonzero on empty store");
`endif

endmodule
